// ===== sv/qtile_pkg.sv =====
// Shared types, constants and helpers for the quadtile encoder.
// No dependencies; used by qtile_cell and quadtile_encode_bbox_neighbor.
package qtile_pkg;

   localparam int ADDR_BITS = 27;
   localparam int MIN_DEPTH = 12;
   localparam int COORD_W   = 33;
   localparam int DEPTH_W   = 5;

   localparam int DEF_MAX_LAT = 90000000;
   localparam int DEF_MAX_LON = 180000000;

   // request codes
   localparam logic [1:0] REQ_ENCODE   = 2'd0;
   localparam logic [1:0] REQ_DECODE   = 2'd1;
   localparam logic [1:0] REQ_NEIGHBOR = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;

   // one beat travelling down the level chain
   typedef struct packed {
      logic                 enc;
      coord_type            lat;
      coord_type            lon;
      coord_type            west;
      coord_type            south;
      logic [ADDR_BITS-1:0] addr;
      logic [DEPTH_W-1:0]   depth;
   } qt_token_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS1,
      ST_PASS2,
      ST_FIN
   } state_type;

   // grid step of a tile: the edge span halved per shift
   function automatic coord_type grid_of(input coord_type maxv, input logic [DEPTH_W-1:0] sh);
      return maxv >>> sh;
   endfunction

   // latitude step per direction (se,s,sw,e,w,ne,n,nw)
   function automatic logic signed [1:0] dir_lat(input logic [2:0] d);
      logic signed [1:0] r;
      unique case (d)
         3'd0, 3'd1, 3'd2: r = -2'sd1;
         3'd3, 3'd4:       r = 2'sd0;
         default:          r = 2'sd1;
      endcase
      return r;
   endfunction

   // longitude step per direction
   function automatic logic signed [1:0] dir_lon(input logic [2:0] d);
      logic signed [1:0] r;
      unique case (d)
         3'd0, 3'd3, 3'd5: r = 2'sd1;
         3'd1, 3'd6:       r = 2'sd0;
         default:          r = -2'sd1;
      endcase
      return r;
   endfunction

   // add, subtract or skip a grid step
   function automatic coord_type apply_step(input coord_type base, input coord_type g,
                                            input logic signed [1:0] st);
      coord_type r;
      if (st == 2'sd1) begin
         r = base + g;
      end else if (st == -2'sd1) begin
         r = base - g;
      end else begin
         r = base;
      end
      return r;
   endfunction

endpackage

// ===== sv/qtile_cell.sv =====
// One level of the quadtile address chain: encodes or decodes one address bit.
// Depends on qtile_pkg.
module qtile_cell
   import qtile_pkg::*;
#(
   parameter int LEVEL   = 0,
   parameter int MAX_LAT = DEF_MAX_LAT,
   parameter int MAX_LON = DEF_MAX_LON
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  qt_token_type in_tok,
   output logic         out_valid,
   output qt_token_type out_tok
);

   localparam int        BIT_POS = ADDR_BITS - 1 - LEVEL;
   localparam bit        IS_LAT  = (LEVEL % 2) == 1;
   localparam coord_type MAXV    = IS_LAT ? coord_type'(MAX_LAT) : coord_type'(MAX_LON);
   localparam coord_type HALF    = MAXV >>> (LEVEL / 2);
   localparam coord_type THRESH  = MAXV - HALF;

   logic         valid_ff;
   qt_token_type tok_ff;
   qt_token_type tok_in;

   // work out this level's bit and move the box corner
   always_comb begin
      logic      active;
      logic      bit_val;
      coord_type coord;
      active  = LEVEL < int'(in_tok.depth);
      tok_in  = in_tok;
      coord   = IS_LAT ? in_tok.lat : in_tok.lon;
      if (in_tok.enc) begin
         bit_val = coord >= THRESH;
      end else begin
         bit_val = in_tok.addr[BIT_POS];
      end
      if (active) begin
         if (in_tok.enc) begin
            tok_in.addr[BIT_POS] = bit_val;
            if (!bit_val) begin
               if (IS_LAT) begin
                  tok_in.lat = in_tok.lat + HALF;
               end else begin
                  tok_in.lon = in_tok.lon + HALF;
               end
            end
         end
         if (bit_val) begin
            if (IS_LAT) begin
               tok_in.south = in_tok.south + HALF;
            end else begin
               tok_in.west = in_tok.west + HALF;
            end
         end
      end
   end

   // hand the beat to the next level
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      tok_ff <= tok_in;
   end

   assign out_valid = valid_ff;
   assign out_tok   = tok_ff;

endmodule

// ===== sv/quadtile_encode_bbox_neighbor.sv =====
// Top level of the quadtile encoder, tile box decoder and neighbor finder.
// Depends on qtile_pkg and qtile_cell.

// One request at a time runs through a chain of 27 level cells, one cell per
// address bit, each registering one address level. An encode or decode request
// takes one pass through the chain and its response is valid once the response
// register loads. A neighbor request takes a decode pass and then an encode pass
// before the response register loads. The next request is taken in the cycle
// after the response register loads, so a new request is not taken before the
// last one is through, and response stalls hold it off further. The response
// register holds a finished beat while the next request is accepted; while it is
// still stalled, a further finished beat waits and the input stays stalled.
// Positions beyond the world saturate to the edge tile, and depths outside
// 12..27 are clamped.
module quadtile_encode_bbox_neighbor
   import qtile_pkg::*;
#(
   parameter int MAX_LAT = DEF_MAX_LAT,
   parameter int MAX_LON = DEF_MAX_LON
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  logic signed [27:0] req_latitude,
   input  logic signed [28:0] req_longitude,
   input  logic [4:0]         req_tile_bits,
   input  logic [30:0]        req_tile_in,
   input  logic [2:0]         req_direction,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [30:0]        rsp_tile_out,
   output logic signed [28:0] rsp_west_edge,
   output logic signed [27:0] rsp_south_edge,
   output logic signed [28:0] rsp_east_edge,
   output logic signed [27:0] rsp_north_edge
);

   localparam coord_type LAT_C = coord_type'(MAX_LAT);
   localparam coord_type LON_C = coord_type'(MAX_LON);

   state_type    state_ff, state_in;
   logic [1:0]   kind_ff;
   logic [30:0]  tile_ff;
   logic [2:0]   dir_ff;
   qt_token_type fin_ff;
   logic         rsp_valid_ff;
   logic [30:0]  rsp_tile_ff;
   logic signed [28:0] rsp_west_ff, rsp_east_ff;
   logic signed [27:0] rsp_south_ff, rsp_north_ff;

   logic         req_accept;
   logic         chain_done;
   logic         rsp_load;
   logic         inj_valid;
   qt_token_type inj_tok;
   qt_token_type req_tok;
   qt_token_type nb_tok;

   logic         link_v   [ADDR_BITS+1];
   qt_token_type link_tok [ADDR_BITS+1];

   assign req_accept = req_valid && !req_stall;
   assign chain_done = link_v[ADDR_BITS];
   assign rsp_load   = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);

   // build the first beat from the request
   always_comb begin
      logic [DEPTH_W-1:0] d;
      if (req_tile_bits < DEPTH_W'(MIN_DEPTH)) begin
         d = DEPTH_W'(MIN_DEPTH);
      end else if (req_tile_bits > DEPTH_W'(ADDR_BITS)) begin
         d = DEPTH_W'(ADDR_BITS);
      end else begin
         d = req_tile_bits;
      end
      req_tok.enc   = req_type == REQ_ENCODE;
      req_tok.lat   = coord_type'(req_latitude);
      req_tok.lon   = coord_type'(req_longitude);
      req_tok.west  = -LON_C;
      req_tok.south = -LAT_C;
      if (req_tok.enc) begin
         req_tok.addr  = '0;
         req_tok.depth = d;
      end else begin
         req_tok.addr  = req_tile_in[30:4];
         req_tok.depth = {1'b0, req_tile_in[3:0]} + DEPTH_W'(MIN_DEPTH);
      end
   end

   // move the decoded tile centre one grid step for the second pass
   always_comb begin
      qt_token_type t;
      coord_type    glon, glat;
      t    = link_tok[ADDR_BITS];
      glon = grid_of(LON_C, (t.depth - DEPTH_W'(1)) >> 1);
      glat = grid_of(LAT_C, (t.depth - DEPTH_W'(2)) >> 1);
      nb_tok.enc   = 1'b1;
      nb_tok.lon   = apply_step(t.west + (glon >>> 1), glon, dir_lon(dir_ff));
      nb_tok.lat   = apply_step(t.south + (glat >>> 1), glat, dir_lat(dir_ff));
      nb_tok.west  = -LON_C;
      nb_tok.south = -LAT_C;
      nb_tok.addr  = '0;
      nb_tok.depth = t.depth;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_PASS1;
            end
         end
         ST_PASS1: begin
            if (chain_done) begin
               state_in = (kind_ff == REQ_NEIGHBOR) ? ST_PASS2 : ST_FIN;
            end
         end
         ST_PASS2: begin
            if (chain_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer: chain injection and request stall
   always_comb begin
      req_stall = 1'b1;
      inj_valid = 1'b0;
      inj_tok   = req_tok;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            inj_valid = req_valid;
         end
         ST_PASS1: begin
            inj_tok   = nb_tok;
            inj_valid = chain_done && (kind_ff == REQ_NEIGHBOR);
         end
         default: begin
            inj_valid = 1'b0;
         end
      endcase
   end

   assign link_v[0]   = inj_valid;
   assign link_tok[0] = inj_tok;

   // one cell per address level
   for (genvar g = 0; g < ADDR_BITS; g++) begin : g_level
      qtile_cell #(
         .LEVEL  (g),
         .MAX_LAT(MAX_LAT),
         .MAX_LON(MAX_LON)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (link_v[g]),
         .in_tok   (link_tok[g]),
         .out_valid(link_v[g+1]),
         .out_tok  (link_tok[g+1])
      );
   end

   // hold request details and the finished beat
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (req_accept) begin
         kind_ff <= req_type;
         tile_ff <= req_tile_in;
         dir_ff  <= req_direction;
      end
      if (chain_done && state_in == ST_FIN) begin
         fin_ff <= link_tok[ADDR_BITS];
      end
   end

   // response register: tile id and box edges
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (rsp_load) begin
         if (kind_ff == REQ_ENCODE || kind_ff == REQ_NEIGHBOR) begin
            rsp_tile_ff <= {fin_ff.addr, 4'(fin_ff.depth - DEPTH_W'(MIN_DEPTH))};
         end else begin
            rsp_tile_ff <= tile_ff;
         end
         rsp_west_ff  <= fin_ff.west[28:0];
         rsp_south_ff <= fin_ff.south[27:0];
         rsp_east_ff  <= 29'(fin_ff.west
                             + grid_of(LON_C, (fin_ff.depth - DEPTH_W'(1)) >> 1));
         rsp_north_ff <= 28'(fin_ff.south
                             + grid_of(LAT_C, (fin_ff.depth - DEPTH_W'(2)) >> 1));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tile_out   = rsp_tile_ff;
   assign rsp_west_edge  = rsp_west_ff;
   assign rsp_south_edge = rsp_south_ff;
   assign rsp_east_edge  = rsp_east_ff;
   assign rsp_north_edge = rsp_north_ff;

endmodule

// ===== bench/quadtile_encode_bbox_neighbor_tb.sv =====
// Testbench for quadtile_encode_bbox_neighbor: encode, box decode and neighbour requests.
// Depends on qtile_pkg and the RTL; predicts every response and checks it.
`timescale 1ns / 100ps

module quadtile_encode_bbox_neighbor_tb;
   import qtile_pkg::*;

   localparam longint LAT_MAX = 90000000;
   localparam longint LON_MAX = 180000000;
   localparam int NUM_RANDOM = 900;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [30:0] tile;
      logic [28:0] west;
      logic [27:0] south;
      logic [28:0] east;
      logic [27:0] north;
   } tile_box_type;

   // compass order matches the direction code: se, s, sw, e, w, ne, n, nw
   typedef enum logic [2:0] {
      DIR_SE, DIR_S, DIR_SW, DIR_E, DIR_W, DIR_NE, DIR_N, DIR_NW
   } compass_type;

   // Encode a position at a given depth into a packed tile id
   function automatic logic [30:0] pack_position(longint lat, longint lon, int depth);
      logic [26:0] addr;
      longint half;
      addr = '0;
      for (int i = 0; i < depth; i++) begin
         addr = addr << 1;
         if (i % 2 == 1) begin
            half = LAT_MAX >>> (i / 2);
            if (lat >= LAT_MAX - half) addr[0] = 1'b1;
            else lat += half;
         end else begin
            half = LON_MAX >>> (i / 2);
            if (lon >= LON_MAX - half) addr[0] = 1'b1;
            else lon += half;
         end
      end
      addr = addr << (27 - depth);
      return {addr, 4'(depth - MIN_DEPTH)};
   endfunction

   // Work out the bounding box of a packed tile id
   function automatic void tile_edges(logic [30:0] tile, output longint w, output longint s,
                                      output longint e, output longint n);
      int depth;
      logic [26:0] addr;
      depth = int'(tile[3:0]) + MIN_DEPTH;
      addr = tile[30:4] >> (27 - depth);
      w = -LON_MAX;
      s = -LAT_MAX;
      for (int i = 0; i < depth; i++) begin
         if (addr[depth-1-i]) begin
            if (i % 2 == 1) s += LAT_MAX >>> (i / 2);
            else w += LON_MAX >>> (i / 2);
         end
      end
      e = w + (LON_MAX >>> ((depth - 1) / 2));
      n = s + (LAT_MAX >>> ((depth - 2) / 2));
   endfunction

   function automatic tile_box_type predict_tile(logic [1:0] kind, logic signed [27:0] lat,
                                                 logic signed [28:0] lon, logic [4:0] bits,
                                                 logic [30:0] tin, logic [2:0] dir);
      tile_box_type r;
      longint w, s, e, n, glon, glat, plat, plon;
      int depth, dlat, dlon;
      if (kind == REQ_ENCODE) begin
         depth = (bits < 12) ? 12 : (bits > 27) ? 27 : int'(bits);
         r.tile = pack_position(longint'(lat), longint'(lon), depth);
      end else if (kind == REQ_NEIGHBOR) begin
         depth = int'(tin[3:0]) + MIN_DEPTH;
         glon = LON_MAX >>> ((depth - 1) >> 1);
         glat = LAT_MAX >>> ((depth - 2) >> 1);
         tile_edges(tin, w, s, e, n);
         case (compass_type'(dir))
            DIR_SE, DIR_S, DIR_SW: dlat = -1;
            DIR_E, DIR_W:          dlat = 0;
            default:               dlat = 1;
         endcase
         case (compass_type'(dir))
            DIR_SE, DIR_E, DIR_NE: dlon = 1;
            DIR_S, DIR_N:          dlon = 0;
            default:               dlon = -1;
         endcase
         plon = w + (glon >>> 1) + dlon * glon;
         plat = s + (glat >>> 1) + dlat * glat;
         r.tile = pack_position(plat, plon, depth);
      end else begin
         r.tile = tin;
      end
      tile_edges(r.tile, w, s, e, n);
      r.west = w[28:0];
      r.south = s[27:0];
      r.east = e[28:0];
      r.north = n[27:0];
      return r;
   endfunction

   // Scoreboard of pending tile results
   class tile_scoreboard;
      tile_box_type pending[$];
      int errors = 0;
      int checked = 0;

      function void note_request(logic [1:0] kind, logic signed [27:0] lat,
                                 logic signed [28:0] lon, logic [4:0] bits,
                                 logic [30:0] tin, logic [2:0] dir);
         pending.push_back(predict_tile(kind, lat, lon, bits, tin, dir));
      endfunction

      function void check_result(tile_box_type got);
         tile_box_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result tile %h", $realtime, got.tile);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (got.tile !== want.tile) begin
            $display("%0t: tile exp %h got %h", $realtime, want.tile, got.tile);
            errors++;
         end
         if (got.west !== want.west) begin
            $display("%0t: west exp %h got %h", $realtime, want.west, got.west);
            errors++;
         end
         if (got.south !== want.south) begin
            $display("%0t: south exp %h got %h", $realtime, want.south, got.south);
            errors++;
         end
         if (got.east !== want.east) begin
            $display("%0t: east exp %h got %h", $realtime, want.east, got.east);
            errors++;
         end
         if (got.north !== want.north) begin
            $display("%0t: north exp %h got %h", $realtime, want.north, got.north);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = '0;
   logic signed [27:0] req_latitude = '0;
   logic signed [28:0] req_longitude = '0;
   logic [4:0] req_tile_bits = '0;
   logic [30:0] req_tile_in = '0;
   logic [2:0] req_direction = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [30:0] rsp_tile_out;
   logic signed [28:0] rsp_west_edge;
   logic signed [27:0] rsp_south_edge;
   logic signed [28:0] rsp_east_edge;
   logic signed [27:0] rsp_north_edge;

   tile_scoreboard board = new();
   bit stimulus_done = 1'b0;
   bit long_hold = 1'b0;
   int idle_cycles = 0;
   int count_kind[4] = '{0, 0, 0, 0};

   quadtile_encode_bbox_neighbor u_top (.*);

   always #2 clock = ~clock;

   // Pick a gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // Offer one beat and hold it until accepted
   task automatic send_request(logic [1:0] kind, logic signed [27:0] lat,
                               logic signed [28:0] lon, logic [4:0] bits,
                               logic [30:0] tin, logic [2:0] dir);
      req_valid <= 1'b1;
      req_type <= kind;
      req_latitude <= lat;
      req_longitude <= lon;
      req_tile_bits <= bits;
      req_tile_in <= tin;
      req_direction <= dir;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, lat, lon, bits, tin, dir);
      count_kind[kind]++;
   endtask

   task automatic idle_sender(int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         req_type <= 2'($urandom);
         req_tile_in <= 31'($urandom);
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic logic [30:0] random_tile();
      logic [30:0] t;
      t = 31'($urandom);
      if ($urandom_range(3) == 0) t[3:0] = 4'($urandom_range(3, 0));
      return t;
   endfunction

   function automatic logic signed [27:0] random_lat();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 28'($urandom);
      if (r == 1) return $urandom_range(1) ? 28'(LAT_MAX) : -28'(LAT_MAX);
      return 28'(longint'($urandom_range(180000000)) - LAT_MAX);
   endfunction

   function automatic logic signed [28:0] random_lon();
      int r;
      r = $urandom_range(9);
      if (r == 0) return 29'($urandom);
      if (r == 1) return $urandom_range(1) ? 29'(LON_MAX) : -29'(LON_MAX);
      return 29'(longint'($urandom_range(360000000)) - LON_MAX);
   endfunction

   // Stimulus
   initial begin
      logic [1:0] kind;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corners, out-of-world positions, clamped depths, decodes and the spare code
      send_request(REQ_ENCODE, 28'(LAT_MAX), 29'(LON_MAX), 5'd27, '0, '0);
      send_request(REQ_ENCODE, -28'(LAT_MAX), -29'(LON_MAX), 5'd12, '0, '0);
      send_request(REQ_ENCODE, 28'sd0, 29'sd0, 5'd20, '0, '0);
      send_request(REQ_ENCODE, 28'h7FFFFFF, 29'hFFFFFFF, 5'd31, '0, '0);
      send_request(REQ_ENCODE, 28'h8000000, 29'h10000000, 5'd0, '0, '0);
      send_request(REQ_ENCODE, 28'sd12345678, -29'sd98765432, 5'd11, '0, '0);
      send_request(REQ_ENCODE, 28'sd1, 29'sd1, 5'd28, '0, '0);
      send_request(REQ_DECODE, '0, '0, '0, 31'h7FFFFFFF, '0);
      send_request(REQ_DECODE, '0, '0, '0, 31'h0, '0);
      send_request(REQ_DECODE, '0, '0, '0, 31'h12345673, '0);
      send_request(2'd3, '0, '0, '0, 31'h5555555F, '0);
      // every direction, from the top-right and bottom-left corner tiles
      for (int d = 0; d < 8; d++) begin
         send_request(REQ_NEIGHBOR, '0, '0, '0, 31'h7FFFFFFF, 3'(d));
         send_request(REQ_NEIGHBOR, '0, '0, '0, 31'h00000000, 3'(d));
      end

      // random traffic
      for (int i = 0; i < NUM_RANDOM; i++) begin
         idle_sender(pick_gap());
         kind = 2'($urandom_range(9) == 0 ? 3 : $urandom_range(2));
         send_request(kind, random_lat(), random_lon(), 5'($urandom),
                      random_tile(), 3'($urandom));
         if (i == NUM_RANDOM / 2) long_hold = 1'b1;
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Receiver: random stalls and one long hold-off while the sender keeps going
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end
         gap = ($urandom_range(3) == 0) ? pick_gap() : 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Check every accepted result beat
   always @(posedge clock) begin
      tile_box_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.tile = rsp_tile_out;
         got.west = rsp_west_edge;
         got.south = rsp_south_edge;
         got.east = rsp_east_edge;
         got.north = rsp_north_edge;
         board.check_result(got);
      end
   end

   // Watchdog: count cycles with no beat on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d results outstanding", board.pending.size());
         $display("quadtile_encode_bbox_neighbor_tb failed");
         $finish;
      end
   end

   // Finish once everything has drained
   initial begin
      wait (stimulus_done);
      wait (board.pending.size() == 0);
      repeat (100) @(posedge clock);
      $display("covered %0d encode, %0d decode, %0d neighbour and %0d spare-code requests",
               count_kind[0], count_kind[1], count_kind[2], count_kind[3]);
      $display("checked %0d results with %0d mismatches", board.checked, board.errors);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("quadtile_encode_bbox_neighbor_tb passed");
      else
         $display("quadtile_encode_bbox_neighbor_tb failed");
      $finish;
   end

endmodule
